// ----- hw/rtl/fmba_pkg.sv -----
// ----------------------------------------------------------------------------
// fmba_pkg
// shared constants, codes and types of the fit memory block allocator
// ----------------------------------------------------------------------------
package fmba_pkg;

   // table geometry
   localparam int BLOCKS    = 16;
   localparam int SIZE_BITS = 16;
   localparam int IDX_BITS  = $clog2(BLOCKS);
   localparam int CNT_BITS  = $clog2(BLOCKS + 1);

   // fixed field widths of the ports
   localparam int FUNC_BITS     = 1;
   localparam int BIDX_BITS     = 4;
   localparam int FIELD_BITS    = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 5;
   localparam int BCOUNT_BITS   = 5;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_BITS-1:0] CSR_STRATEGY    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLOCK_COUNT = 2'd1;

   localparam logic [BCOUNT_BITS-1:0] BLOCK_COUNT_RESET = 5'd16;

   // item function codes
   localparam logic [FUNC_BITS-1:0] FUNC_LOAD    = 1'b0;
   localparam logic [FUNC_BITS-1:0] FUNC_REQUEST = 1'b1;

   typedef enum logic [1:0] {
      STRAT_FIRST = 2'd0,
      STRAT_NEXT  = 2'd1,
      STRAT_BEST  = 2'd2,
      STRAT_WORST = 2'd3
   } strategy_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic scan_issue;
      logic load_write;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic start_load;
      logic count_zero;
      logic scan_last;
   } status_type;

endpackage

// ----- hw/rtl/fmba_ram.sv -----
// ----------------------------------------------------------------------------
// fmba_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module fmba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/fmba_ctrl.sv -----
// ----------------------------------------------------------------------------
// fmba_ctrl
// sequencer of the allocator: accept, load, table scan, drain and commit
// ----------------------------------------------------------------------------
module fmba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  fmba_pkg::status_type  status,
   output fmba_pkg::cmd_type     cmd,
   output logic                  busy
);

   fmba_pkg::state_type state_ff;
   fmba_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fmba_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         fmba_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               if (status.start_load) begin
                  state_in = fmba_pkg::ST_LOAD;
               end else if (status.count_zero) begin
                  state_in = fmba_pkg::ST_COMMIT;
               end else begin
                  state_in = fmba_pkg::ST_SCAN;
               end
            end
         end
         fmba_pkg::ST_LOAD: begin
            cmd.load_write = 1'b1;
            state_in       = fmba_pkg::ST_IDLE;
         end
         fmba_pkg::ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) begin
               state_in = fmba_pkg::ST_DRAIN;
            end
         end
         fmba_pkg::ST_DRAIN: begin
            state_in = fmba_pkg::ST_COMMIT;
         end
         fmba_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = fmba_pkg::ST_IDLE;
         end
         default: begin
            state_in = fmba_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/fmba_dp.sv -----
// ----------------------------------------------------------------------------
// fmba_dp
// allocator datapath: capacity table, scan compare, result and csr registers
// ----------------------------------------------------------------------------
module fmba_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fmba_pkg::cmd_type                     cmd,
   output fmba_pkg::status_type                  status,
   input  logic [fmba_pkg::FUNC_BITS-1:0]        req_func,
   input  logic [fmba_pkg::BIDX_BITS-1:0]        req_block_index,
   input  logic [fmba_pkg::FIELD_BITS-1:0]       req_block_size,
   input  logic [fmba_pkg::FIELD_BITS-1:0]       req_req_size,
   output logic                                  rsp_strobe,
   output logic                                  rsp_granted,
   output logic [fmba_pkg::BIDX_BITS-1:0]        rsp_chosen_block,
   output logic [fmba_pkg::FIELD_BITS-1:0]       rsp_fragment,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fmba_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [fmba_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   // configuration
   fmba_pkg::strategy_type                strategy_ff;
   logic [fmba_pkg::BCOUNT_BITS-1:0]      block_count_ff;
   logic [fmba_pkg::CNT_BITS-1:0]         count;

   // captured word
   logic [fmba_pkg::BIDX_BITS-1:0]        bidx_ff;
   logic [fmba_pkg::SIZE_BITS-1:0]        bsize_ff;
   logic [fmba_pkg::SIZE_BITS-1:0]        req_ff;

   // scan state
   logic [fmba_pkg::IDX_BITS-1:0]         next_start_ff;
   logic [fmba_pkg::IDX_BITS-1:0]         scan_cnt_ff;
   logic [fmba_pkg::IDX_BITS-1:0]         pos_ff;
   logic [fmba_pkg::IDX_BITS-1:0]         scan_begin;
   logic [fmba_pkg::CNT_BITS-1:0]         pos_inc;
   logic                                  rd_valid_ff;
   logic [fmba_pkg::IDX_BITS-1:0]         rd_tag_ff;
   logic [fmba_pkg::SIZE_BITS-1:0]        rd_data;
   logic                                  pick_valid_ff;
   logic [fmba_pkg::IDX_BITS-1:0]         pick_idx_ff;
   logic [fmba_pkg::SIZE_BITS-1:0]        pick_cap_ff;
   logic                                  fits;
   logic                                  better;
   logic                                  take;

   // table write port
   logic                                  wr_en;
   logic [fmba_pkg::IDX_BITS-1:0]         wr_addr;
   logic [fmba_pkg::SIZE_BITS-1:0]        wr_data;
   logic                                  load_in_range;
   logic [fmba_pkg::SIZE_BITS-1:0]        remain;

   // result registers
   logic                                  rsp_strobe_ff;
   logic                                  rsp_granted_ff;
   logic [fmba_pkg::BIDX_BITS-1:0]        rsp_chosen_block_ff;
   logic [fmba_pkg::FIELD_BITS-1:0]       rsp_fragment_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff    <= fmba_pkg::STRAT_FIRST;
         block_count_ff <= fmba_pkg::BLOCK_COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            fmba_pkg::CSR_STRATEGY: begin
               strategy_ff <= fmba_pkg::strategy_type'(csr_wdata[1:0]);
            end
            fmba_pkg::CSR_BLOCK_COUNT: begin
               block_count_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // blocks in use, saturated to the table depth
   always_comb begin
      if (int'(block_count_ff) > fmba_pkg::BLOCKS) begin
         count = fmba_pkg::CNT_BITS'(fmba_pkg::BLOCKS);
      end else begin
         count = fmba_pkg::CNT_BITS'(block_count_ff);
      end
   end

   // next fit starts at the last used block unless the pointer is stale
   always_comb begin
      scan_begin = '0;
      if (strategy_ff == fmba_pkg::STRAT_NEXT &&
          fmba_pkg::CNT_BITS'(next_start_ff) < count) begin
         scan_begin = next_start_ff;
      end
   end

   assign pos_inc = fmba_pkg::CNT_BITS'(pos_ff) + fmba_pkg::CNT_BITS'(1);

   assign status.start_load = (req_func == fmba_pkg::FUNC_LOAD);
   assign status.count_zero = (count == '0);
   assign status.scan_last  =
      (fmba_pkg::CNT_BITS'(scan_cnt_ff) + fmba_pkg::CNT_BITS'(1)) == count;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         bidx_ff  <= req_block_index;
         bsize_ff <= fmba_pkg::SIZE_BITS'(req_block_size);
         req_ff   <= fmba_pkg::SIZE_BITS'(req_req_size);
      end
   end

   // scan address walk, wraps at the count in use
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         scan_cnt_ff <= '0;
         pos_ff      <= scan_begin;
      end else if (cmd.scan_issue) begin
         scan_cnt_ff <= scan_cnt_ff + fmba_pkg::IDX_BITS'(1);
         if (pos_inc == count) begin
            pos_ff <= '0;
         end else begin
            pos_ff <= fmba_pkg::IDX_BITS'(pos_inc);
         end
      end
      rd_tag_ff <= pos_ff;
   end

   assign fits   = rd_data >= req_ff;
   assign better = !pick_valid_ff ||
                   (strategy_ff == fmba_pkg::STRAT_BEST  && rd_data < pick_cap_ff) ||
                   (strategy_ff == fmba_pkg::STRAT_WORST && rd_data > pick_cap_ff);
   assign take   = rd_valid_ff && fits && better;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         pick_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_issue;
         if (cmd.capture) begin
            pick_valid_ff <= 1'b0;
         end else if (take) begin
            pick_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pick_idx_ff <= rd_tag_ff;
         pick_cap_ff <= rd_data;
      end
   end

   assign load_in_range = int'(bidx_ff) < fmba_pkg::BLOCKS;
   assign remain        = pick_cap_ff - req_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pick_idx_ff;
      wr_data = remain;
      if (cmd.load_write) begin
         wr_en   = load_in_range;
         wr_addr = fmba_pkg::IDX_BITS'(bidx_ff);
         wr_data = bsize_ff;
      end else if (cmd.commit) begin
         wr_en = pick_valid_ff;
      end
   end

   fmba_ram #(
      .WIDTH (fmba_pkg::SIZE_BITS),
      .DEPTH (fmba_pkg::BLOCKS)
   ) u_capacity (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         next_start_ff <= '0;
      end else if (cmd.load_write) begin
         next_start_ff <= '0;
      end else if (cmd.commit && pick_valid_ff &&
                   strategy_ff == fmba_pkg::STRAT_NEXT) begin
         next_start_ff <= pick_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.load_write | cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_write) begin
         rsp_granted_ff      <= 1'b0;
         rsp_chosen_block_ff <= bidx_ff;
         rsp_fragment_ff     <= fmba_pkg::FIELD_BITS'(bsize_ff);
      end else if (cmd.commit) begin
         rsp_granted_ff <= pick_valid_ff;
         if (pick_valid_ff) begin
            rsp_chosen_block_ff <= fmba_pkg::BIDX_BITS'(pick_idx_ff);
            rsp_fragment_ff     <= fmba_pkg::FIELD_BITS'(remain);
         end else begin
            rsp_chosen_block_ff <= '0;
            rsp_fragment_ff     <= '0;
         end
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_block = rsp_chosen_block_ff;
   assign rsp_fragment     = rsp_fragment_ff;

endmodule

// ----- hw/rtl/fit_memory_block_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// fit_memory_block_allocator_unit
// first, next, best and worst fit allocator over a table of block capacities
// ----------------------------------------------------------------------------
// a word is taken when start is high and busy is low; every word gives exactly
// one result word, shown for a single cycle with rsp_strobe high, and the
// receiver cannot stall it. a load word (req_func 0) writes one block's
// capacity, clears the next-fit pointer and echoes index and size; busy stays
// high for one cycle. an allocation request walks the capacity table one
// block per cycle through the single read port of the capacity ram, so busy
// stays high through the scan of the blocks in use, a drain state and the
// commit state (only the commit state when no block is in use). the result
// word is shown in the first cycle with busy low again. the user must write
// strategy and block count over the csr port only while the unit is idle;
// the unit itself does not enforce this. capacities read back before a
// block was ever loaded are undefined.
// ----------------------------------------------------------------------------
module fit_memory_block_allocator_unit (
   input  logic                                  clock,
   input  logic                                  reset,

   // request channel
   input  logic                                  start,
   output logic                                  busy,
   input  logic [fmba_pkg::FUNC_BITS-1:0]        req_func,
   input  logic [fmba_pkg::BIDX_BITS-1:0]        req_block_index,
   input  logic [fmba_pkg::FIELD_BITS-1:0]       req_block_size,
   input  logic [fmba_pkg::FIELD_BITS-1:0]       req_req_size,

   // result channel, no back-pressure
   output logic                                  rsp_strobe,
   output logic                                  rsp_granted,
   output logic [fmba_pkg::BIDX_BITS-1:0]        rsp_chosen_block,
   output logic [fmba_pkg::FIELD_BITS-1:0]       rsp_fragment,

   // configuration channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fmba_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [fmba_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   // command and status between sequencer and datapath
   fmba_pkg::cmd_type    cmd;
   fmba_pkg::status_type status;

   // sequencer: idle, load, scan, drain of the last ram read, commit
   fmba_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // datapath: capacity ram, running pick, next-fit pointer, result registers
   fmba_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_func),
      .req_block_index  (req_block_index),
      .req_block_size   (req_block_size),
      .req_req_size     (req_req_size),
      .rsp_strobe       (rsp_strobe),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_fragment     (rsp_fragment),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

`ifndef ASSERT_OFF
   // a result word only follows a cycle in which a word was in flight
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a word in flight");

   // each word yields one result, never two in consecutive cycles
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // an accepted word always occupies the unit in the following cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // a load word is echoed in the next cycle and never reports a grant
   a_load_echo: assert property (@(posedge clock) disable iff (reset)
      cmd.load_write |=> (rsp_strobe && !rsp_granted))
      else $error("load word not echoed as an ungranted result");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the fit memory block allocator: a behavioural
// predictor of the capacity table follows every accepted word, and each
// result word is checked field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb;
   import fmba_pkg::*;

   // unused register indexes, writes there must change nothing
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HI = 2'd3;

   // cycles without any handshake before the run is declared hung; a request
   // over sixteen blocks holds busy through the whole scan and sender idle
   // stretches are short, so this is many times the slowest legal stretch
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 24;

   typedef struct packed {
      logic                  granted;
      logic [BIDX_BITS-1:0]  block;
      logic [FIELD_BITS-1:0] fragment;
   } grant_word_type;

   // dut ports
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [FUNC_BITS-1:0]     req_func = FUNC_LOAD;
   logic [BIDX_BITS-1:0]     req_block_index = '0;
   logic [FIELD_BITS-1:0]    req_block_size = '0;
   logic [FIELD_BITS-1:0]    req_req_size = '0;
   logic                     rsp_strobe;
   logic                     rsp_granted;
   logic [BIDX_BITS-1:0]     rsp_chosen_block;
   logic [FIELD_BITS-1:0]    rsp_fragment;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // predictor state: capacity table, next-fit pointer and the two registers
   logic [FIELD_BITS-1:0]    free_cap [BLOCKS];
   logic [BIDX_BITS-1:0]     next_fit_ptr = '0;
   strategy_type             cur_strategy = STRAT_FIRST;
   logic [BCOUNT_BITS-1:0]   cur_count = BLOCK_COUNT_RESET;

   // predicted result words, oldest first
   grant_word_type           pending_grants [$];
   grant_word_type           want;

   int                       mismatches = 0;
   int                       quiet_cycles = 0;
   int                       sender_idle_pct = 12;

   fit_memory_block_allocator_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_block_index  (req_block_index),
      .req_block_size   (req_block_size),
      .req_req_size     (req_req_size),
      .rsp_strobe       (rsp_strobe),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_fragment     (rsp_fragment),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // one line per mismatch
   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns mismatch: %s", $time, what);
   endtask

   // predictor: applies one accepted word to the table and queues its result
   task automatic predict_grant(input logic [FUNC_BITS-1:0] func,
                                input logic [BIDX_BITS-1:0] idx,
                                input logic [FIELD_BITS-1:0] bsize,
                                input logic [FIELD_BITS-1:0] rsize);
      grant_word_type res;
      int          used;
      int          pick;
      int          pos;
      int          j;
      res = '0;
      if (func == FUNC_LOAD) begin
         // load echoes index and size, and sends next fit back to block 0
         free_cap[idx] = bsize;
         next_fit_ptr  = '0;
         res.block     = idx;
         res.fragment  = bsize;
      end else begin
         // count above the table size saturates
         used = (cur_count > BLOCKS) ? BLOCKS : int'(cur_count);
         pick = -1;
         // a stale pointer past the blocks in use restarts the scan at 0
         pos  = (int'(next_fit_ptr) < used) ? int'(next_fit_ptr) : 0;
         for (j = 0; j < used; j++) begin
            case (cur_strategy)
               STRAT_FIRST: begin
                  if (pick < 0 && free_cap[j] >= rsize) pick = j;
               end
               STRAT_NEXT: begin
                  if (pick < 0 && free_cap[pos] >= rsize) pick = pos;
                  pos = (pos + 1 == used) ? 0 : pos + 1;
               end
               STRAT_BEST: begin
                  if (free_cap[j] >= rsize && (pick < 0 || free_cap[j] < free_cap[pick]))
                     pick = j;
               end
               default: begin
                  if (free_cap[j] >= rsize && (pick < 0 || free_cap[j] > free_cap[pick]))
                     pick = j;
               end
            endcase
         end
         // a refused request leaves table and pointer alone, result all zero
         if (pick >= 0) begin
            free_cap[pick] = free_cap[pick] - rsize;
            if (cur_strategy == STRAT_NEXT) next_fit_ptr = BIDX_BITS'(pick);
            res.granted  = 1'b1;
            res.block    = BIDX_BITS'(pick);
            res.fragment = free_cap[pick];
         end
      end
      pending_grants.push_back(res);
   endtask

   // drives one word until it is taken, then predicts; the sender holds
   // start low in a share of the cycles; fields the function ignores carry
   // random values
   task automatic send_word(input logic [FUNC_BITS-1:0] func,
                            input logic [BIDX_BITS-1:0] idx,
                            input logic [FIELD_BITS-1:0] size);
      logic [BIDX_BITS-1:0]  w_idx;
      logic [FIELD_BITS-1:0] w_bsize;
      logic [FIELD_BITS-1:0] w_rsize;
      logic                  accepted;
      w_idx   = (func == FUNC_LOAD) ? idx : BIDX_BITS'($urandom);
      w_bsize = (func == FUNC_LOAD) ? size : FIELD_BITS'($urandom);
      w_rsize = (func == FUNC_LOAD) ? FIELD_BITS'($urandom) : size;
      req_func        <= func;
      req_block_index <= w_idx;
      req_block_size  <= w_bsize;
      req_req_size    <= w_rsize;
      start           <= ($urandom_range(0, 99) >= sender_idle_pct);
      do begin
         @(posedge clock);
         accepted = start && !busy;
         if (!accepted) start <= ($urandom_range(0, 99) >= sender_idle_pct);
      end while (!accepted);
      predict_grant(func, w_idx, w_bsize, w_rsize);
   endtask

   // waits for the unit to go idle, then writes a spare index, the strategy
   // and the block count back to back with valid held high throughout
   task automatic program_registers(input logic [CSR_DATA_BITS-1:0] strat_data,
                                    input logic [CSR_DATA_BITS-1:0] count_data);
      start <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= $urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO;
      csr_wdata <= CSR_DATA_BITS'($urandom);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_STRATEGY;
      csr_wdata <= strat_data;
      do @(posedge clock); while (!csr_ready);
      cur_strategy = strategy_type'(strat_data[1:0]);
      csr_index <= CSR_BLOCK_COUNT;
      csr_wdata <= count_data;
      do @(posedge clock); while (!csr_ready);
      cur_count = count_data;
      csr_valid <= 1'b0;
   endtask

   // every block loaded under the reset settings, with ties and both extremes
   task automatic test_table_load();
      logic [FIELD_BITS-1:0] caps [BLOCKS];
      int i;
      caps = '{16'd0, 16'd300, 16'd1200, 16'd500, 16'd800, 16'd500, 16'd2000, 16'd40,
               16'd800, 16'd100, 16'd3000, 16'd60, 16'd700, 16'd900, 16'd50, 16'hffff};
      for (i = 0; i < BLOCKS; i++) send_word(FUNC_LOAD, BIDX_BITS'(i), caps[i]);
   endtask

   // first fit at reset strategy: zero size into an empty block, full size
   task automatic test_first_fit();
      send_word(FUNC_REQUEST, '0, 16'd0);
      send_word(FUNC_REQUEST, '0, 16'd400);
      send_word(FUNC_REQUEST, '0, 16'hffff);
      send_word(FUNC_REQUEST, '0, 16'hffff);
   endtask

   // next fit keeps its block, wraps, and restarts when the pointer goes stale
   task automatic test_next_fit();
      program_registers({3'd0, STRAT_NEXT}, 5'd16);
      send_word(FUNC_REQUEST, '0, 16'd1000);
      send_word(FUNC_REQUEST, '0, 16'd900);
      send_word(FUNC_REQUEST, '0, 16'd2500);
      program_registers({3'd7, STRAT_NEXT}, 5'd4);
      send_word(FUNC_REQUEST, '0, 16'd100);
      send_word(FUNC_LOAD, 4'd2, 16'hffff);
      send_word(FUNC_REQUEST, '0, 16'd200);
   endtask

   // no blocks in use refuses everything; an oversized count saturates
   task automatic test_count_limits();
      program_registers({3'd5, STRAT_FIRST}, 5'd0);
      send_word(FUNC_REQUEST, '0, 16'd0);
      program_registers({3'd2, STRAT_WORST}, 5'd31);
      send_word(FUNC_REQUEST, '0, 16'd10);
   endtask

   // best fit tie goes to the lower index; an oversized request is refused
   task automatic test_tie_break();
      program_registers({3'd0, STRAT_BEST}, 5'd16);
      send_word(FUNC_REQUEST, '0, 16'd500);
      send_word(FUNC_REQUEST, '0, 16'hffff);
      send_word(FUNC_REQUEST, '0, 16'd800);
   endtask

   // random words under one setting: mostly requests aimed at real
   // capacities (exact fits, partial fits, just too large) with some refills
   task automatic test_random_phase(input strategy_type strat,
                                    input logic [BCOUNT_BITS-1:0] count,
                                    input int n_words);
      logic [FIELD_BITS-1:0] size;
      logic [FIELD_BITS-1:0] top;
      logic [BIDX_BITS-1:0]  idx;
      int used;
      int probe;
      int roll;
      int k;
      int j;
      program_registers({3'($urandom_range(0, 7)), strat}, count);
      used = (count > BLOCKS) ? BLOCKS : int'(count);
      for (k = 0; k < n_words; k++) begin
         probe = (used > 0) ? $urandom_range(0, used - 1) : 0;
         roll  = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 15) begin
            idx = (used > 0 && roll < 70) ? BIDX_BITS'(probe) : BIDX_BITS'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 35)      size = FIELD_BITS'($urandom);
            else if (roll < 70) size = FIELD_BITS'($urandom_range(0, 1000));
            else if (roll < 85) size = FIELD_BITS'($urandom_range(1, 4) * 256);
            else if (roll < 95) size = '1;
            else                size = '0;
            send_word(FUNC_LOAD, idx, size);
         end else begin
            top = '0;
            for (j = 0; j < used; j++) if (free_cap[j] > top) top = free_cap[j];
            if (roll < 10)      size = '0;
            else if (roll < 40) size = free_cap[probe];
            else if (roll < 70) size = FIELD_BITS'($urandom_range(0, free_cap[probe]));
            else if (roll < 80) size = (top == '1) ? top : top + 16'd1;
            else if (roll < 90) size = FIELD_BITS'($urandom_range(0, 255));
            else                size = FIELD_BITS'($urandom);
            send_word(FUNC_REQUEST, '0, size);
         end
      end
   endtask

   // result checker: every strobe is compared with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_grants.size() == 0) begin
            report_mismatch("result word with no prediction waiting");
         end else begin
            want = pending_grants.pop_front();
            if (rsp_granted !== want.granted)
               report_mismatch($sformatf("granted %0b, predicted %0b",
                                         rsp_granted, want.granted));
            if (rsp_chosen_block !== want.block)
               report_mismatch($sformatf("chosen_block %0d, predicted %0d",
                                         rsp_chosen_block, want.block));
            if (rsp_fragment !== want.fragment)
               report_mismatch($sformatf("fragment %0d, predicted %0d",
                                         rsp_fragment, want.fragment));
         end
      end
   end

   // watchdog on cycles in which no handshake of any kind completes
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // test sequence
   initial begin : main_sequence
      logic [BCOUNT_BITS-1:0] phase_counts [12];
      int g;
      int s;
      phase_counts = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd16, 5'd9, 5'd2, 5'd16,
                       5'd0, 5'd12, 5'd17, 5'd16};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under the reset register values first
      test_table_load();
      test_first_fit();
      test_next_fit();
      test_count_limits();
      test_tie_break();

      // random part: light sender gaps, heavy gaps, then back to back
      for (g = 0; g < 3; g++) begin
         sender_idle_pct = (g == 0) ? 12 : (g == 1) ? 77 : 0;
         for (s = 0; s < 4; s++)
            test_random_phase(strategy_type'(s), phase_counts[g * 4 + s], 120);
      end

      // let the last words come out, then a short quiet tail
      start <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
